/* hw/rtl/afds_pkg.sv */
// Package with shared types, constants and helper functions for the ADC frame deinterleaver.
`timescale 1ns / 1ps
`default_nettype none
package afds_pkg;

   localparam int NUM_LINES = 4;
   localparam int MAX_POINTS = 8192;

   localparam int CODE_W = 13;
   localparam int POINT_W = 13;
   localparam int PPC_W = 14;
   localparam int VALUE_W = 28;
   localparam int RANGE_W = 3;
   localparam int INDEX_W = 3;
   localparam int SCALE_W = 12;

   localparam logic [INDEX_W-1:0] REG_RANGE_CH0 = 3'd0;
   localparam logic [INDEX_W-1:0] REG_RANGE_CH1 = 3'd1;
   localparam logic [INDEX_W-1:0] REG_RANGE_CH2 = 3'd2;
   localparam logic [INDEX_W-1:0] REG_RANGE_CH3 = 3'd3;
   localparam logic [INDEX_W-1:0] REG_POINTS = 3'd4;

   localparam logic [RANGE_W-1:0] RANGE_RESET = 3'd0;
   localparam logic [RANGE_W-1:0] RANGE_LAST_ON = 3'd3;
   localparam logic [PPC_W-1:0] PPC_RESET = 14'd1024;

   localparam logic [SCALE_W-1:0] SCALE_8192MV = SCALE_W'(8192000 / 2048);
   localparam logic [SCALE_W-1:0] SCALE_4096MV = SCALE_W'(4096000 / 2048);
   localparam logic [SCALE_W-1:0] SCALE_2048MV = SCALE_W'(2048000 / 2048);
   localparam logic [SCALE_W-1:0] SCALE_1024MV = SCALE_W'(1024000 / 2048);

   localparam logic signed [VALUE_W-1:0] OVL_POS = VALUE_W'(100000000);
   localparam logic signed [VALUE_W-1:0] OVL_NEG = -VALUE_W'(100000000);

   localparam logic [PPC_W-1:0] LIMIT_1 = PPC_W'(MAX_POINTS / 1);
   localparam logic [PPC_W-1:0] LIMIT_2 = PPC_W'(MAX_POINTS / 2);
   localparam logic [PPC_W-1:0] LIMIT_3 = PPC_W'(MAX_POINTS / 3);
   localparam logic [PPC_W-1:0] LIMIT_4 = PPC_W'(MAX_POINTS / 4);

   typedef struct packed {
      logic [1:0] slot;
      logic [1:0] line;
      logic [POINT_W-1:0] point;
      logic [11:0] low_code;
      logic overload;
      logic [1:0] scale_sel;
      logic frame_overload;
      logic last;
   } afds_item_type;

   function automatic logic [SCALE_W-1:0] scale_of(input logic [1:0] sel);
      logic [SCALE_W-1:0] result;
      case (sel)
         2'd0: result = SCALE_8192MV;
         2'd1: result = SCALE_4096MV;
         2'd2: result = SCALE_2048MV;
         default: result = SCALE_1024MV;
      endcase
      return result;
   endfunction

   function automatic logic [PPC_W-1:0] limit_of(input logic [2:0] nact);
      logic [PPC_W-1:0] result;
      case (nact)
         3'd1: result = LIMIT_1;
         3'd2: result = LIMIT_2;
         3'd3: result = LIMIT_3;
         default: result = LIMIT_4;
      endcase
      return result;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/adc_frame_deinterleave_scaler_top.sv */
// Top level of the ADC frame deinterleaver and scaler.
// Each request is registered first in the two-entry queue and then in the output register.
// Throughput: one request per cycle while the queue is not full; rsp_stall can hold the flow.
// The two-entry queue between front end and back end lets each side stall on its own.
// Reset is synchronous and active high; it restores the register defaults and starts a new frame.
`timescale 1ns / 1ps
`default_nettype none
module adc_frame_deinterleave_scaler_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [afds_pkg::INDEX_W-1:0] csr_index,
   input wire logic [afds_pkg::PPC_W-1:0] csr_wdata,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [afds_pkg::CODE_W-1:0] req_raw_code,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_active_slot,
   output logic [1:0] rsp_physical_channel,
   output logic [afds_pkg::POINT_W-1:0] rsp_point_index,
   output logic signed [afds_pkg::VALUE_W-1:0] rsp_sample_value,
   output logic rsp_overload,
   output logic rsp_frame_overload,
   output logic rsp_last
);
   import afds_pkg::*;

   logic q_push;
   logic q_pop;
   logic q_full;
   logic q_not_empty;
   afds_item_type push_item;
   afds_item_type head_item;

   afds_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_raw_code(req_raw_code),
      .q_full(q_full),
      .req_stall(req_stall),
      .q_push(q_push),
      .q_item(push_item)
   );

   afds_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(push_item),
      .pop(q_pop),
      .full(q_full),
      .not_empty(q_not_empty),
      .head_item(head_item)
   );

   afds_back u_back (
      .clock(clock),
      .reset(reset),
      .q_not_empty(q_not_empty),
      .q_head(head_item),
      .q_pop(q_pop),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_active_slot(rsp_active_slot),
      .rsp_physical_channel(rsp_physical_channel),
      .rsp_point_index(rsp_point_index),
      .rsp_sample_value(rsp_sample_value),
      .rsp_overload(rsp_overload),
      .rsp_frame_overload(rsp_frame_overload),
      .rsp_last(rsp_last)
   );

endmodule
`default_nettype wire

/* hw/rtl/afds_front.sv */
// Front end: configuration registers, frame counters and classification of each raw request.
`timescale 1ns / 1ps
`default_nettype none
module afds_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [afds_pkg::INDEX_W-1:0] csr_index,
   input wire logic [afds_pkg::PPC_W-1:0] csr_wdata,
   input wire logic req_valid,
   input wire logic [afds_pkg::CODE_W-1:0] req_raw_code,
   input wire logic q_full,
   output logic req_stall,
   output logic q_push,
   output afds_pkg::afds_item_type q_item
);
   import afds_pkg::*;

   logic [RANGE_W-1:0] range_ff [NUM_LINES];
   logic [RANGE_W-1:0] range_in [NUM_LINES];
   logic [PPC_W-1:0] ppc_ff, ppc_in;
   logic [POINT_W-1:0] point_ff, point_in;
   logic [1:0] slot_ff, slot_in;
   logic sticky_ff, sticky_in;

   logic [NUM_LINES-1:0] enabled;
   logic [2:0] nact;
   logic [PPC_W-1:0] npts;
   logic [PPC_W-1:0] limit;
   logic restart;
   logic [POINT_W-1:0] point_cur;
   logic [1:0] slot_cur;
   logic sticky_cur;
   logic [2:0] seen;
   logic [1:0] line_sel;
   logic [1:0] scale_sel;
   logic accept;
   logic ovl;
   logic last_f;

   always_comb begin
      for (int i = 0; i < NUM_LINES; i++) begin
         enabled[i] = (range_ff[i] <= RANGE_LAST_ON);
      end
      nact = 3'($countones(enabled));
   end

   always_comb begin
      limit = limit_of(nact);
      npts = (ppc_ff == '0) ? PPC_W'(1) : ppc_ff;
      if (npts > limit) begin
         npts = limit;
      end
      restart = ({1'b0, slot_ff} >= nact) || ({1'b0, point_ff} >= npts);
      point_cur = restart ? '0 : point_ff;
      slot_cur = restart ? '0 : slot_ff;
      sticky_cur = restart ? 1'b0 : sticky_ff;
   end

   always_comb begin
      seen = '0;
      line_sel = '0;
      scale_sel = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         if (enabled[i]) begin
            if (seen == {1'b0, slot_cur}) begin
               line_sel = 2'(i);
               scale_sel = range_ff[i][1:0];
            end
            seen = seen + 3'd1;
         end
      end
   end

   assign req_stall = q_full;
   assign accept = req_valid && !q_full;
   assign ovl = req_raw_code[12];
   assign last_f = ({1'b0, point_cur} == npts - PPC_W'(1)) && ({1'b0, slot_cur} == nact - 3'd1);
   assign q_push = accept && (nact != 3'd0);

   always_comb begin
      q_item.slot = slot_cur;
      q_item.line = line_sel;
      q_item.point = point_cur;
      q_item.low_code = req_raw_code[11:0];
      q_item.overload = ovl;
      q_item.scale_sel = scale_sel;
      q_item.frame_overload = sticky_cur | ovl;
      q_item.last = last_f;
   end

   always_comb begin
      range_in = range_ff;
      ppc_in = ppc_ff;
      point_in = point_ff;
      slot_in = slot_ff;
      sticky_in = sticky_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RANGE_CH0, REG_RANGE_CH1, REG_RANGE_CH2, REG_RANGE_CH3: begin
               range_in[csr_index[1:0]] = csr_wdata[RANGE_W-1:0];
               point_in = '0;
               slot_in = '0;
               sticky_in = 1'b0;
            end
            REG_POINTS: begin
               ppc_in = csr_wdata;
               point_in = '0;
               slot_in = '0;
               sticky_in = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (q_push) begin
         if (last_f) begin
            point_in = '0;
            slot_in = '0;
            sticky_in = 1'b0;
         end else if ({1'b0, slot_cur} + 3'd1 >= nact) begin
            point_in = point_cur + POINT_W'(1);
            slot_in = '0;
            sticky_in = sticky_cur | ovl;
         end else begin
            point_in = point_cur;
            slot_in = slot_cur + 2'd1;
            sticky_in = sticky_cur | ovl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            range_ff[i] <= RANGE_RESET;
         end
         ppc_ff <= PPC_RESET;
         point_ff <= '0;
         slot_ff <= '0;
         sticky_ff <= 1'b0;
      end else begin
         range_ff <= range_in;
         ppc_ff <= ppc_in;
         point_ff <= point_in;
         slot_ff <= slot_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/afds_queue.sv */
// Two-entry queue that decouples the front end from the scaling back end.
`timescale 1ns / 1ps
`default_nettype none
module afds_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire afds_pkg::afds_item_type push_item,
   input wire logic pop,
   output logic full,
   output logic not_empty,
   output afds_pkg::afds_item_type head_item
);
   import afds_pkg::*;

   afds_item_type entry_ff [2];
   afds_item_type entry_in [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_item;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/afds_back.sv */
// Back end: scales the queued sample and holds the result in the output register.
`timescale 1ns / 1ps
`default_nettype none
module afds_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_not_empty,
   input wire afds_pkg::afds_item_type q_head,
   output logic q_pop,
   input wire logic rsp_stall,
   output logic rsp_valid,
   output logic [1:0] rsp_active_slot,
   output logic [1:0] rsp_physical_channel,
   output logic [afds_pkg::POINT_W-1:0] rsp_point_index,
   output logic signed [afds_pkg::VALUE_W-1:0] rsp_sample_value,
   output logic rsp_overload,
   output logic rsp_frame_overload,
   output logic rsp_last
);
   import afds_pkg::*;

   logic valid_ff, valid_in;
   afds_item_type item_ff;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [11:0] centered;
   logic signed [SCALE_W:0] scale_s;
   logic signed [SCALE_W+12:0] product;

   assign q_pop = q_not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      centered = signed'({~q_head.low_code[11], q_head.low_code[10:0]});
      scale_s = signed'({1'b0, scale_of(q_head.scale_sel)});
      product = centered * scale_s;
      if (q_head.overload) begin
         value_in = q_head.low_code[11] ? OVL_POS : OVL_NEG;
      end else begin
         value_in = VALUE_W'(product);
      end
   end

   always_comb begin
      if (q_pop) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_head;
         value_ff <= value_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_active_slot = item_ff.slot;
   assign rsp_physical_channel = item_ff.line;
   assign rsp_point_index = item_ff.point;
   assign rsp_sample_value = value_ff;
   assign rsp_overload = item_ff.overload;
   assign rsp_frame_overload = item_ff.frame_overload;
   assign rsp_last = item_ff.last;

endmodule
`default_nettype wire

/* hw/rtl/afds_checker.sv */
// Port-level checker for the ADC frame deinterleaver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module afds_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [1:0] rsp_active_slot,
   input wire logic [1:0] rsp_physical_channel,
   input wire logic signed [afds_pkg::VALUE_W-1:0] rsp_sample_value,
   input wire logic rsp_overload,
   input wire logic rsp_frame_overload
);
   import afds_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("A response is valid right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("A stalled response was dropped.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overload |-> rsp_frame_overload &&
      (rsp_sample_value == OVL_POS || rsp_sample_value == OVL_NEG))
      else $error("An overloaded sample has a wrong value or frame flag.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_slot <= rsp_physical_channel)
      else $error("The active slot exceeds the physical channel.");

endmodule

bind adc_frame_deinterleave_scaler_top afds_checker u_checker (.*);
`default_nettype wire
